[rtl/core/mfq_pkg.sv]
// Shared types and constants for the multilevel feedback queue scheduler core.
// Used by the core; depends on nothing else.
`default_nettype none

package mfq_pkg;

   localparam int DEF_MAX_LEVELS  = 9;
   localparam int DEF_LEVEL_DEPTH = 32;

   localparam int LEVEL_W  = 4;
   localparam int ID_W     = 8;
   localparam int TIME_W   = 8;
   localparam int SLICE_W  = 9;
   localparam int STATUS_W = 3;
   localparam int CFG_W    = 4;

   localparam logic [CFG_W-1:0]   RESET_LEVELS = 4'd9;
   localparam logic [SLICE_W-1:0] SLICE_MAX    = 9'd511;

   localparam logic OP_ENQUEUE  = 1'b0;
   localparam logic OP_DISPATCH = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ENQUEUED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RAN      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd4;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [TIME_W-1:0]  time_left;
      logic [SLICE_W-1:0] slices;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

[rtl/core/mfq_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; no package dependency.
`default_nettype none

module mfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         storage_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= storage_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/multilevel_feedback_queue_scheduler_core.sv]
// Multilevel feedback queue scheduler: per-level FIFOs in one entry RAM, head/tail/count
// per level in flops. Depends on mfq_pkg and mfq_ram.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  opcode, process_id, service_time, priority_class
//   rsp_     out        rsp_valid/rsp_ready  status, served_id, served_level, time_left,
//                                            slices_run, finished
//   csr_     in         csr_valid/csr_ready  levels_in_use
//
// An enqueue passes through S_ENQ; a dispatch reads the entry RAM in S_DEQ and writes back
// in S_DEQ2 (then S_PUSH when the lower level is full and the process is requeued at its own
// level); an empty dispatch passes through S_NONE. The entry RAM read is registered.
// Reset is synchronous; queues come up empty and no clearing pass is needed.
// A new request is taken while the previous result waits in the output register; a stalled
// result only holds the block in its final step.
`default_nettype none

module multilevel_feedback_queue_scheduler_core #(
   parameter int MAX_LEVELS  = mfq_pkg::DEF_MAX_LEVELS,
   parameter int LEVEL_DEPTH = mfq_pkg::DEF_LEVEL_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_opcode,
   input  wire logic [mfq_pkg::ID_W-1:0]      req_process_id,
   input  wire logic [mfq_pkg::TIME_W-1:0]    req_service_time,
   input  wire logic [mfq_pkg::LEVEL_W-1:0]   req_priority_class,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [mfq_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [mfq_pkg::ID_W-1:0]      rsp_served_id,
   output logic      [mfq_pkg::LEVEL_W-1:0]   rsp_served_level,
   output logic      [mfq_pkg::TIME_W-1:0]    rsp_time_left,
   output logic      [mfq_pkg::SLICE_W-1:0]   rsp_slices_run,
   output logic                               rsp_finished,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [mfq_pkg::CFG_W-1:0]     csr_levels_in_use
);

   localparam int LIDX_W    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int PTR_W     = $clog2(LEVEL_DEPTH);
   localparam int CNT_W     = $clog2(LEVEL_DEPTH + 1);
   localparam int MEM_DEPTH = MAX_LEVELS * LEVEL_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int Q_W       = mfq_pkg::TIME_W + 1;
   localparam int SH_W      = 5;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ENQ,
      S_NONE,
      S_DEQ,
      S_DEQ2,
      S_PUSH
   } state_type;

   state_type                      state_ff, state_in;
   logic [mfq_pkg::CFG_W-1:0]      levels_ff, levels_in;
   logic [LIDX_W-1:0]              lvl_ff, lvl_in;
   logic [LIDX_W-1:0]              top_ff, top_in;
   logic [mfq_pkg::ID_W-1:0]       id_ff, id_in;
   logic [mfq_pkg::TIME_W-1:0]     time_ff, time_in;
   logic [mfq_pkg::SLICE_W-1:0]    slice_ff, slice_in;
   logic [PTR_W-1:0]               head_ff [MAX_LEVELS];
   logic [PTR_W-1:0]               head_in [MAX_LEVELS];
   logic [PTR_W-1:0]               tail_ff [MAX_LEVELS];
   logic [PTR_W-1:0]               tail_in [MAX_LEVELS];
   logic [CNT_W-1:0]               count_ff [MAX_LEVELS];
   logic [CNT_W-1:0]               count_in [MAX_LEVELS];

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [mfq_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [mfq_pkg::ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic [mfq_pkg::LEVEL_W-1:0]    rsp_level_ff, rsp_level_in;
   logic [mfq_pkg::TIME_W-1:0]     rsp_time_ff, rsp_time_in;
   logic [mfq_pkg::SLICE_W-1:0]    rsp_slices_ff, rsp_slices_in;
   logic                           rsp_finished_ff, rsp_finished_in;

   logic                           rsp_free;
   logic                           load_rsp;
   logic                           accept;
   logic [LIDX_W-1:0]              cur_top;
   logic [LIDX_W-1:0]              class_lvl;
   logic [LIDX_W-1:0]              found_lvl;
   logic                           found_any;
   logic [LIDX_W-1:0]              lvl_sel;
   logic [PTR_W-1:0]               head_rd, tail_rd;
   logic [CNT_W-1:0]               cnt_rd;
   logic                           lvl_full;
   logic                           do_push, do_pop;

   logic                           ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]              ram_addr;
   mfq_pkg::entry_type             ram_wr_data, ram_rd_data;

   logic [SH_W-1:0]                shift;
   logic [Q_W-1:0]                 quantum;
   logic [mfq_pkg::TIME_W-1:0]     new_time;
   logic [mfq_pkg::SLICE_W-1:0]    new_slices;
   logic                           zero_time;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(LEVEL_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // Effective top level from the register, clamped into 1..MAX_LEVELS levels.
   always_comb begin
      if (levels_ff == '0) begin
         cur_top = '0;
      end else if ({1'b0, levels_ff} > (mfq_pkg::CFG_W + 1)'(MAX_LEVELS)) begin
         cur_top = LIDX_W'(MAX_LEVELS - 1);
      end else begin
         cur_top = LIDX_W'(levels_ff - mfq_pkg::CFG_W'(1));
      end
      if (req_priority_class > mfq_pkg::LEVEL_W'(cur_top)) begin
         class_lvl = cur_top;
      end else begin
         class_lvl = LIDX_W'(req_priority_class);
      end
   end

   // Highest non-empty level within the levels in use.
   always_comb begin
      found_lvl = '0;
      found_any = 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
         if (LIDX_W'(i) <= cur_top && count_ff[i] != '0) begin
            found_lvl = LIDX_W'(i);
            found_any = 1'b1;
         end
      end
   end

   // The pointer arrays are read at one level per cycle.
   always_comb begin
      unique case (state_ff)
         S_DEQ2:  lvl_sel = (lvl_ff == '0) ? '0 : lvl_ff - LIDX_W'(1);
         default: lvl_sel = lvl_ff;
      endcase
   end

   assign head_rd  = head_ff[lvl_sel];
   assign tail_rd  = tail_ff[lvl_sel];
   assign cnt_rd   = count_ff[lvl_sel];
   assign lvl_full = (cnt_rd == CNT_W'(LEVEL_DEPTH));

   // Slice arithmetic on the entry just read.
   always_comb begin
      zero_time = (ram_rd_data.time_left == '0);
      shift     = SH_W'(top_ff - lvl_ff);
      quantum   = Q_W'(1) << shift;
      if (shift >= SH_W'(mfq_pkg::TIME_W) || {1'b0, ram_rd_data.time_left} <= quantum) begin
         new_time = '0;
      end else begin
         new_time = mfq_pkg::TIME_W'({1'b0, ram_rd_data.time_left} - quantum);
      end
      if (ram_rd_data.slices == mfq_pkg::SLICE_MAX) begin
         new_slices = ram_rd_data.slices;
      end else begin
         new_slices = ram_rd_data.slices + mfq_pkg::SLICE_W'(1);
      end
   end

   always_comb begin
      state_in        = state_ff;
      levels_in       = levels_ff;
      lvl_in          = lvl_ff;
      top_in          = top_ff;
      id_in           = id_ff;
      time_in         = time_ff;
      slice_in        = slice_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_id_in       = rsp_id_ff;
      rsp_level_in    = rsp_level_ff;
      rsp_time_in     = rsp_time_ff;
      rsp_slices_in   = rsp_slices_ff;
      rsp_finished_in = rsp_finished_ff;
      load_rsp        = 1'b0;
      do_push         = 1'b0;
      do_pop          = 1'b0;
      ram_rd_en       = 1'b0;
      ram_wr_data     = '{id: id_ff, time_left: time_ff, slices: slice_ff};

      if (csr_valid && csr_ready) begin
         levels_in = csr_levels_in_use;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               top_in   = cur_top;
               id_in    = req_process_id;
               time_in  = req_service_time;
               slice_in = '0;
               if (req_opcode == mfq_pkg::OP_ENQUEUE) begin
                  lvl_in   = class_lvl;
                  state_in = S_ENQ;
               end else if (found_any) begin
                  lvl_in   = found_lvl;
                  state_in = S_DEQ;
               end else begin
                  state_in = S_NONE;
               end
            end
         end
         S_ENQ: begin
            if (rsp_free) begin
               load_rsp        = 1'b1;
               rsp_id_in       = id_ff;
               rsp_level_in    = mfq_pkg::LEVEL_W'(lvl_ff);
               rsp_slices_in   = '0;
               rsp_finished_in = 1'b0;
               if (lvl_full) begin
                  rsp_status_in = mfq_pkg::ST_FULL;
                  rsp_time_in   = '0;
               end else begin
                  do_push       = 1'b1;
                  rsp_status_in = mfq_pkg::ST_ENQUEUED;
                  rsp_time_in   = time_ff;
               end
               state_in = S_IDLE;
            end
         end
         S_NONE: begin
            if (rsp_free) begin
               load_rsp        = 1'b1;
               rsp_status_in   = mfq_pkg::ST_EMPTY;
               rsp_id_in       = '0;
               rsp_level_in    = '0;
               rsp_time_in     = '0;
               rsp_slices_in   = '0;
               rsp_finished_in = 1'b0;
               state_in        = S_IDLE;
            end
         end
         S_DEQ: begin
            ram_rd_en = 1'b1;
            do_pop    = 1'b1;
            state_in  = S_DEQ2;
         end
         S_DEQ2: begin
            id_in       = ram_rd_data.id;
            time_in     = new_time;
            slice_in    = new_slices;
            ram_wr_data = '{id: ram_rd_data.id, time_left: new_time, slices: new_slices};
            if (!zero_time && new_time != '0 && lvl_ff != '0 && lvl_full) begin
               // Lower level is full: requeue at its own level in S_PUSH.
               state_in = S_PUSH;
            end else if (rsp_free) begin
               load_rsp        = 1'b1;
               rsp_id_in       = ram_rd_data.id;
               rsp_level_in    = mfq_pkg::LEVEL_W'(lvl_ff);
               if (zero_time) begin
                  rsp_status_in   = mfq_pkg::ST_DROPPED;
                  rsp_time_in     = '0;
                  rsp_slices_in   = ram_rd_data.slices;
                  rsp_finished_in = 1'b0;
               end else begin
                  rsp_status_in   = mfq_pkg::ST_RAN;
                  rsp_time_in     = new_time;
                  rsp_slices_in   = new_slices;
                  rsp_finished_in = (new_time == '0);
                  do_push         = (new_time != '0);
               end
               state_in = S_IDLE;
            end
         end
         S_PUSH: begin
            if (rsp_free) begin
               do_push         = 1'b1;
               load_rsp        = 1'b1;
               rsp_status_in   = mfq_pkg::ST_RAN;
               rsp_id_in       = id_ff;
               rsp_level_in    = mfq_pkg::LEVEL_W'(lvl_ff);
               rsp_time_in     = time_ff;
               rsp_slices_in   = slice_ff;
               rsp_finished_in = 1'b0;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Queue pointer updates, one level per cycle.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in[lvl_sel]  = ptr_inc(tail_rd);
         count_in[lvl_sel] = cnt_rd + CNT_W'(1);
      end else if (do_pop) begin
         head_in[lvl_sel]  = ptr_inc(head_rd);
         count_in[lvl_sel] = cnt_rd - CNT_W'(1);
      end
   end

   assign ram_wr_en = do_push;
   assign ram_addr  = ADDR_W'(lvl_sel) * ADDR_W'(LEVEL_DEPTH)
                    + ADDR_W'(do_pop ? head_rd : tail_rd);

   mfq_ram #(
      .WIDTH (mfq_pkg::ENTRY_W),
      .DEPTH (MEM_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         levels_ff       <= mfq_pkg::RESET_LEVELS;
         lvl_ff          <= '0;
         top_ff          <= '0;
         id_ff           <= '0;
         time_ff         <= '0;
         slice_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         rsp_status_ff   <= '0;
         rsp_id_ff       <= '0;
         rsp_level_ff    <= '0;
         rsp_time_ff     <= '0;
         rsp_slices_ff   <= '0;
         rsp_finished_ff <= 1'b0;
         for (int i = 0; i < MAX_LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff        <= state_in;
         levels_ff       <= levels_in;
         lvl_ff          <= lvl_in;
         top_ff          <= top_in;
         id_ff           <= id_in;
         time_ff         <= time_in;
         slice_ff        <= slice_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_status_ff   <= rsp_status_in;
         rsp_id_ff       <= rsp_id_in;
         rsp_level_ff    <= rsp_level_in;
         rsp_time_ff     <= rsp_time_in;
         rsp_slices_ff   <= rsp_slices_in;
         rsp_finished_ff <= rsp_finished_in;
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         count_ff        <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_served_id    = rsp_id_ff;
   assign rsp_served_level = rsp_level_ff;
   assign rsp_time_left    = rsp_time_ff;
   assign rsp_slices_run   = rsp_slices_ff;
   assign rsp_finished     = rsp_finished_ff;

   // An accepted transaction always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("request accepted but core stayed idle");

   // The level being touched never holds more than its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_rd <= CNT_W'(LEVEL_DEPTH))
      else $error("queue count exceeds level depth");

   // Never pop an empty level or push into a full one.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(do_pop && cnt_rd == '0) && !(do_push && lvl_full))
      else $error("queue overflow or underflow");

   // Finishing an enqueue produces a result on the next cycle.
   a_enq_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ENQ && rsp_free) |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("enqueue finished without a result");

endmodule

`default_nettype wire
